@@ sv/sib_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sib_pkg: shared types and constants for the sorted insert buffer
// Request opcodes, response kinds, payload widths and sequencer states.
// ----------------------------------------------------------------------------
package sib_pkg;

   localparam int WordWidth = 32;   // stored value width
   localparam int PosWidth  = 5;    // reported position width
   localparam int OpWidth   = 2;    // opcode and response kind width
   localparam int MaxDump   = 32;   // most responses one dump produces

   // request opcodes (req_tuser)
   localparam logic [OpWidth-1:0] CMD_INSERT = 2'd0;
   localparam logic [OpWidth-1:0] CMD_DUMP   = 2'd1;
   localparam logic [OpWidth-1:0] CMD_CLEAR  = 2'd2;

   // response kinds (rsp_tuser)
   localparam logic [OpWidth-1:0] KIND_INSERT = 2'd0;
   localparam logic [OpWidth-1:0] KIND_ELEM   = 2'd1;
   localparam logic [OpWidth-1:0] KIND_EMPTY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_FILL,
      ST_RESP,
      ST_DUMP
   } state_type;

endpackage : sib_pkg
`default_nettype wire

@@ sv/sib_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sib_store: entry memory of the sorted insert buffer
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sib_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire  [AW-1:0]                 wr_addr,
   input  wire  [sib_pkg::WordWidth-1:0] wr_data,
   input  wire  [AW-1:0]                 rd_addr,
   output logic [sib_pkg::WordWidth-1:0] rd_data
);

   logic [sib_pkg::WordWidth-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : sib_store
`default_nettype wire

@@ sv/sorted_insert_buffer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_buffer_unit: bounded store of signed values kept in order
// Insert, dump and clear requests over a stream interface.
// ----------------------------------------------------------------------------
// Keeps up to CAPACITY signed 32-bit values in ascending order in a single
// port-pair memory. An insert walks the store from its top entry downward
// through one shared signed compare, moving every entry that is greater than
// or equal to the new value up by one slot per cycle, then drops the value
// into the hole; it reports the final index (mod 32), whether the entry it
// landed in front of was equal, or overflow when the store is full. A dump
// streams one stored value per cycle while the output register is free (at
// most 32, tlast on the final one), the first behind the registered memory
// read; an empty dump, a clear and an overflow each give one kind-2 /
// overflow response. Every response waits for a free output register. The
// block takes one request at a time; a response waits in an output register
// while the sequencer returns to idle. Opcode 3 is accepted and ignored.
// ----------------------------------------------------------------------------
module sorted_insert_buffer_unit #(
   parameter int CAPACITY = 32
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [1:0]  req_tuser,   // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] element, [36:32] position,
                                    // [37] dup_found, [38] overflow, [39] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = sib_pkg::WordWidth;
   localparam int PW = sib_pkg::PosWidth;
   localparam int DumpLen = (CAPACITY < sib_pkg::MaxDump) ? CAPACITY : sib_pkg::MaxDump;
   localparam logic [CW-1:0] CapCount  = CW'(CAPACITY);
   localparam logic [CW-1:0] DumpCount = CW'(DumpLen);

   // sequencer state
   sib_pkg::state_type state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            slot_ff, slot_in;     // hole that the new value fills
   logic [AW-1:0]            idx_ff, idx_in;       // dump index
   logic [WW-1:0]            value_ff, value_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic                     dup_ff, dup_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [39:0]              rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic                     rsp_last_ff, rsp_last_in;

   // memory ports
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [WW-1:0]            wr_data;
   logic [AW-1:0]            rd_addr;
   logic [WW-1:0]            rd_data;

   // shared compare unit
   logic                     cmp_ge;
   logic                     cmp_eq;

   // response load strobe and payload
   logic                     out_free;
   logic                     load;
   logic [1:0]               ld_kind;
   logic [WW-1:0]            ld_elem;
   logic [PW-1:0]            ld_pos;
   logic                     ld_dup;
   logic                     ld_ovf;
   logic                     ld_last;

   // index extended before the modulo-32 position cut
   logic [AW+PW-1:0]         slot_ext;
   logic [AW+PW-1:0]         idx_ext;
   logic [CW-1:0]            idx_next_cnt;

   sib_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cmp_ge = $signed(rd_data) >= $signed(value_ff);
   assign cmp_eq = rd_data == value_ff;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign slot_ext     = (AW+PW)'(slot_ff);
   assign idx_ext      = (AW+PW)'(idx_ff);
   assign idx_next_cnt = CW'(idx_ff) + CW'(1);

   assign req_tready = (state_ff == sib_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      cmd_in   = cmd_ff;
      dup_in   = dup_ff;
      wr_en    = 1'b0;
      wr_addr  = slot_ff;
      wr_data  = value_ff;
      rd_addr  = '0;
      load     = 1'b0;
      ld_kind  = sib_pkg::KIND_EMPTY;
      ld_elem  = '0;
      ld_pos   = '0;
      ld_dup   = 1'b0;
      ld_ovf   = 1'b0;
      ld_last  = 1'b1;

      unique case (state_ff)
         sib_pkg::ST_IDLE: begin
            rd_addr = (req_tuser == sib_pkg::CMD_DUMP) ? '0 : AW'(count_ff - CW'(1));
            if (req_tvalid) begin
               value_in = req_tdata;
               cmd_in   = req_tuser;
               dup_in   = 1'b0;
               slot_in  = AW'(count_ff);
               idx_in   = '0;
               unique case (req_tuser)
                  sib_pkg::CMD_INSERT: begin
                     if (count_ff == CapCount) begin
                        state_in = sib_pkg::ST_RESP;
                     end else if (count_ff == '0) begin
                        state_in = sib_pkg::ST_INS_FILL;
                     end else begin
                        state_in = sib_pkg::ST_INS_SCAN;
                     end
                  end
                  sib_pkg::CMD_DUMP: begin
                     state_in = (count_ff == '0) ? sib_pkg::ST_RESP : sib_pkg::ST_DUMP;
                  end
                  sib_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = sib_pkg::ST_RESP;
                  end
                  default: begin
                     state_in = sib_pkg::ST_IDLE;   // unused opcode
                  end
               endcase
            end
         end

         // rd_data holds the entry just below the hole
         sib_pkg::ST_INS_SCAN: begin
            rd_addr = slot_ff - AW'(2);
            if (cmp_ge) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               dup_in  = cmp_eq;
               slot_in = slot_ff - AW'(1);
               if (slot_ff == AW'(1)) begin
                  state_in = sib_pkg::ST_INS_FILL;
               end
            end else begin
               state_in = sib_pkg::ST_INS_FILL;
            end
         end

         sib_pkg::ST_INS_FILL: begin
            wr_en = 1'b1;
            if (out_free) begin
               load     = 1'b1;
               ld_kind  = sib_pkg::KIND_INSERT;
               ld_pos   = slot_ext[PW-1:0];
               ld_dup   = dup_ff;
               count_in = count_ff + CW'(1);
               state_in = sib_pkg::ST_IDLE;
            end
         end

         // overflow report, empty dump or clear acknowledge
         sib_pkg::ST_RESP: begin
            if (out_free) begin
               load = 1'b1;
               if (cmd_ff == sib_pkg::CMD_INSERT) begin
                  ld_kind = sib_pkg::KIND_INSERT;
                  ld_ovf  = 1'b1;
               end
               state_in = sib_pkg::ST_IDLE;
            end
         end

         // keep rereading the current entry while the output is stalled
         sib_pkg::ST_DUMP: begin
            rd_addr = out_free ? idx_ff + AW'(1) : idx_ff;
            if (out_free) begin
               load    = 1'b1;
               ld_kind = sib_pkg::KIND_ELEM;
               ld_elem = rd_data;
               ld_pos  = idx_ext[PW-1:0];
               ld_last = (idx_next_cnt == DumpCount) || (idx_next_cnt == count_ff);
               if (ld_last) begin
                  state_in = sib_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end

         default: begin
            state_in = sib_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, ld_ovf, ld_dup, ld_pos, ld_elem};
         rsp_kind_in  = ld_kind;
         rsp_last_in  = ld_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sib_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      cmd_ff      <= cmd_in;
      dup_ff      <= dup_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // the fill count never passes the capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("entry count above capacity");

   // completing an insert grows the store by exactly one
   a_fill_grows : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sib_pkg::ST_INS_FILL) && out_free |=>
      count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the store");

   // dumped elements only come from a non-empty store
   a_dump_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sib_pkg::ST_DUMP) |-> count_ff != '0)
      else $error("dump running on an empty store");

   // the scan never runs on an empty hole index
   a_scan_slot : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sib_pkg::ST_INS_SCAN) |-> slot_ff != '0)
      else $error("insert scan below the first entry");
`endif

endmodule : sorted_insert_buffer_unit
`default_nettype wire

@@ bench/tb_sorted_insert_buffer_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_buffer_unit: self-checking bench for the sorted insert buffer
// Streams insert, dump, clear and unused-opcode requests into the unit with
// bursty valid and a stalling ready. Every accepted request is run through a
// local ordered-store model, and each response is checked field by field.
// ----------------------------------------------------------------------------
module tb_sorted_insert_buffer_unit;

   localparam int Capacity = 32;
   localparam logic [sib_pkg::OpWidth-1:0] CMD_NONE = 2'd3;   // unused opcode, ignored
   localparam logic [31:0] ValMin = 32'h8000_0000;
   localparam logic [31:0] ValMax = 32'h7fff_ffff;
   localparam int StimTarget = 190;                  // directed plus random, ~200 in all

   // one pending request; drain_first holds it back until nothing is in flight
   typedef struct {
      logic [sib_pkg::OpWidth-1:0] cmd;
      logic [31:0]                 value;
      bit                          drain_first;
   } sib_request_type;

   typedef struct packed {
      logic [sib_pkg::OpWidth-1:0]  kind;
      logic [31:0]                  element;
      logic [sib_pkg::PosWidth-1:0] position;
      logic                         dup_found;
      logic                         overflow;
      logic                         last;
   } sib_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;     // [31:0] value
   logic [1:0]  req_tuser  = '0;     // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [31:0] element, [36:32] position,
                                     // [37] dup_found, [38] overflow, [39] zero
   logic [1:0]  rsp_tuser;           // [1:0] kind
   logic        rsp_tlast;

   sib_request_type request_q[$];
   sib_result_type  result_due_q[$];

   // ordered-store model state
   logic [31:0] store_vals[Capacity];
   int          store_count = 0;

   // in-flight accounting: issued by the driver, retired by the monitor
   int results_issued  = 0;
   int results_checked = 0;
   int fail_count      = 0;

   // sender burst shaping
   int burst_left = 0;
   int gap_left   = 0;

   // receiver stall pattern
   logic [1:0] stall_mode   = 2'd0;
   int         pattern_left = 0;
   int         beat         = 0;

   // stimulus generation bookkeeping
   int gen_fill   = 0;
   int stim_items = 0;

   sorted_insert_buffer_unit #(
      .CAPACITY(Capacity)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic sib_result_type make_result(
         input logic [sib_pkg::OpWidth-1:0] kind,
         input logic [31:0] element,
         input int position,
         input logic dup, input logic ovf,
         input logic last);
      sib_result_type r;
      r.kind      = kind;
      r.element   = element;
      r.position  = position[sib_pkg::PosWidth-1:0];
      r.dup_found = dup;
      r.overflow  = ovf;
      r.last      = last;
      return r;
   endfunction

   // Applies one accepted request to the store model and queues the responses
   // it should produce. Returns how many were queued.
   function automatic int store_model_step(input logic [sib_pkg::OpWidth-1:0] op,
                                           input logic [31:0] value);
      int   slot;
      int   idx;
      int   span;
      logic found;
      logic dup;
      slot  = store_count;
      found = 1'b0;
      dup   = 1'b0;
      span  = 0;
      case (op)
         sib_pkg::CMD_INSERT: begin
            if (store_count >= Capacity) begin
               // full: dropped, overflow report only
               result_due_q.push_back(make_result(sib_pkg::KIND_INSERT, '0, 0,
                                                  1'b0, 1'b1, 1'b1));
               return 1;
            end
            // first entry >= value, signed order; new value lands ahead of equals
            for (idx = 0; idx < store_count; idx++) begin
               if (!found && $signed(store_vals[idx]) >= $signed(value)) begin
                  slot  = idx;
                  found = 1'b1;
               end
            end
            dup = found && (store_vals[slot] == value);
            for (idx = store_count; idx > slot; idx--)
               store_vals[idx] = store_vals[idx-1];
            store_vals[slot] = value;
            store_count++;
            result_due_q.push_back(make_result(sib_pkg::KIND_INSERT, '0, slot,
                                               dup, 1'b0, 1'b1));
            return 1;
         end
         sib_pkg::CMD_DUMP: begin
            if (store_count == 0) begin
               result_due_q.push_back(make_result(sib_pkg::KIND_EMPTY, '0, 0,
                                                  1'b0, 1'b0, 1'b1));
               return 1;
            end
            span = (store_count > sib_pkg::MaxDump) ? sib_pkg::MaxDump : store_count;
            for (idx = 0; idx < span; idx++)
               result_due_q.push_back(make_result(sib_pkg::KIND_ELEM, store_vals[idx],
                                                  idx, 1'b0, 1'b0, idx == span - 1));
            return span;
         end
         sib_pkg::CMD_CLEAR: begin
            store_count = 0;
            result_due_q.push_back(make_result(sib_pkg::KIND_EMPTY, '0, 0,
                                               1'b0, 1'b0, 1'b1));
            return 1;
         end
         default: return 0;   // unused opcode: no state change, no response
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps, holds a request
   // until it is taken. The model is advanced at the accepting edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      logic took;
      logic offer;
      int   produced;
      took     = req_tvalid && req_tready;
      offer    = 1'b0;
      produced = 0;
      if (reset) begin
         store_count = 0;
         burst_left  = $urandom_range(1, 16);
         gap_left    = 0;
         req_tvalid <= 1'b0;
      end else begin
         if (took) begin
            produced = store_model_step(request_q[0].cmd, request_q[0].value);
            request_q.delete(0);
            burst_left--;
            if (burst_left <= 0) begin
               // a third of the gaps are zero, so some bursts run back to back
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (req_tvalid && !took) begin
            offer = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (request_q.size() > 0) begin
            // drain request: wait until every queued response has been seen
            if (!(request_q[0].drain_first &&
                  (took || results_issued != results_checked)))
               offer = 1'b1;
         end
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= request_q[0].value;
            req_tuser <= request_q[0].cmd;
         end
         results_issued <= results_issued + produced;
      end
   end

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", label, want, got);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Response monitor: checks each taken response against the oldest
   // expectation, and drives ready from a pattern redrawn after a random run
   // (always ready, coin flip, one in four, mostly stalled).
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      sib_result_type want;
      if (reset) begin
         rsp_tready   <= 1'b0;
         stall_mode   <= 2'd0;
         pattern_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_due_q.size() == 0) begin
               $error("unexpected response: kind %0d, tdata %0h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = result_due_q.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_tuser));
               compare_field("element", want.element, rsp_tdata[31:0]);
               compare_field("position", 32'(want.position), 32'(rsp_tdata[36:32]));
               compare_field("dup_found", 32'(want.dup_found), 32'(rsp_tdata[37]));
               compare_field("overflow", 32'(want.overflow), 32'(rsp_tdata[38]));
               compare_field("tdata pad", 32'd0, 32'(rsp_tdata[39]));
               compare_field("last", 32'(want.last), 32'(rsp_tlast));
               results_checked <= results_checked + 1;
            end
         end
         beat <= beat + 1;
         if (pattern_left == 0) begin
            stall_mode   <= 2'($urandom_range(0, 3));
            pattern_left <= $urandom_range(20, 80);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_mode)
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
            2'd2:    rsp_tready <= (beat[1:0] == 2'd0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // mostly full-range values; narrow mode piles up duplicates; extremes now and then
   function automatic logic [31:0] pick_value(input bit narrow);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         case ($urandom_range(0, 3))
            0:       return ValMin;
            1:       return ValMax;
            2:       return 32'd0;
            default: return 32'hffff_ffff;
         endcase
      end
      if (narrow && roll < 7)
         return 32'(int'($urandom_range(0, 6)) - 3);
      return $urandom;
   endfunction

   task automatic queue_request(input logic [sib_pkg::OpWidth-1:0] cmd,
                                input logic [31:0] value,
                                input bit drain_first);
      sib_request_type item;
      item.cmd         = cmd;
      item.value       = value;
      item.drain_first = drain_first || ($urandom_range(0, 24) == 0);
      request_q.push_back(item);
      if (cmd != CMD_NONE)
         stim_items++;
      if (cmd == sib_pkg::CMD_CLEAR)
         gen_fill = 0;
      else if (cmd == sib_pkg::CMD_INSERT && gen_fill < Capacity)
         gen_fill++;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int  episode;
      int  n;
      int  k;
      bit  narrow;
      bit  fill_done;
      fill_done = 1'b0;

      // directed: empty dump, extremes, duplicates, ignored opcode, clear
      queue_request(sib_pkg::CMD_DUMP,   $urandom,      1'b0);   // dump of empty store
      queue_request(sib_pkg::CMD_INSERT, 32'd0,         1'b0);
      queue_request(sib_pkg::CMD_INSERT, ValMin,        1'b0);
      queue_request(sib_pkg::CMD_INSERT, ValMax,        1'b0);
      queue_request(sib_pkg::CMD_INSERT, 32'hffff_ffff, 1'b0);
      queue_request(sib_pkg::CMD_INSERT, 32'd0,         1'b0);   // duplicate mid-list
      queue_request(sib_pkg::CMD_INSERT, 32'd1,         1'b0);
      queue_request(sib_pkg::CMD_INSERT, ValMin,        1'b0);   // duplicate at the bottom
      queue_request(sib_pkg::CMD_INSERT, ValMax,        1'b0);   // duplicate at the top
      queue_request(sib_pkg::CMD_INSERT, 32'h5555_5555, 1'b0);
      queue_request(sib_pkg::CMD_INSERT, 32'haaaa_aaaa, 1'b0);
      queue_request(CMD_NONE,            $urandom,      1'b0);   // unused opcode
      queue_request(sib_pkg::CMD_DUMP,   $urandom,      1'b0);
      queue_request(sib_pkg::CMD_CLEAR,  $urandom,      1'b0);
      queue_request(sib_pkg::CMD_DUMP,   $urandom,      1'b1);   // empty, after a drain
      queue_request(sib_pkg::CMD_CLEAR,  $urandom,      1'b0);   // clear of an empty store
      queue_request(sib_pkg::CMD_INSERT, 32'd7,         1'b0);
      queue_request(CMD_NONE,            32'hffff_ffff, 1'b0);
      queue_request(sib_pkg::CMD_DUMP,   32'hffff_ffff, 1'b0);

      // random episodes; the first one always fills the store past capacity
      while (stim_items < StimTarget) begin
         episode = fill_done ? $urandom_range(0, 9) : 5;
         narrow  = 1'($urandom_range(0, 1));
         case (episode)
            0, 1, 2, 3, 4: begin
               if ($urandom_range(0, 2) != 0)
                  queue_request(sib_pkg::CMD_CLEAR, $urandom, 1'b0);
               n = $urandom_range(1, 12);
               for (k = 0; k < n; k++) begin
                  queue_request(sib_pkg::CMD_INSERT, pick_value(narrow), 1'b0);
                  if ($urandom_range(0, 5) == 0)
                     queue_request(sib_pkg::CMD_DUMP, $urandom, 1'b0);
               end
               queue_request(sib_pkg::CMD_DUMP, $urandom, 1'b0);
            end
            5, 6: begin
               // fill to capacity, a few overflowing inserts, then a full-length dump
               fill_done = 1'b1;
               queue_request(sib_pkg::CMD_CLEAR, $urandom, 1'b0);
               n = Capacity + $urandom_range(1, 3);
               for (k = 0; k < n; k++) begin
                  queue_request(sib_pkg::CMD_INSERT, pick_value(narrow), 1'b0);
                  if ($urandom_range(0, 11) == 0)
                     queue_request(sib_pkg::CMD_DUMP, $urandom, 1'b0);
               end
               queue_request(sib_pkg::CMD_DUMP, $urandom, 1'b1);
            end
            7: begin
               // noise: any opcode, any value
               for (k = 0; k < 10; k++)
                  queue_request(2'($urandom_range(0, 3)), $urandom, 1'b0);
            end
            default: begin
               // grow whatever is there, possibly into overflow
               n = $urandom_range(1, 10);
               for (k = 0; k < n; k++)
                  queue_request(sib_pkg::CMD_INSERT, pick_value(narrow), 1'b0);
               queue_request(sib_pkg::CMD_DUMP, $urandom, 1'b0);
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || result_due_q.size() != 0 ||
             results_issued != results_checked)
         @(posedge clock);
      // room for a late or spurious response: longest insert walk plus margin
      repeat (48) @(posedge clock);

      if (fail_count == 0 && result_due_q.size() == 0)
         $display("sorted_insert_buffer_unit verification clean");
      else
         $display("sorted_insert_buffer_unit verification failed");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("sorted_insert_buffer_unit verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/sib_pkg.sv
sv/sib_store.sv
sv/sorted_insert_buffer_unit.sv
bench/tb_sorted_insert_buffer_unit.sv
